@@ design/uv_sphere_vertex_generator_top_macros.svh @@
// Assertion macros shared by the UV sphere vertex generator.
// Depends on signals named clock and reset in the module that uses them.
`ifndef UV_SPHERE_VERTEX_GENERATOR_TOP_MACROS_SVH
`define UV_SPHERE_VERTEX_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define UVS_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("uvs assertion failed");

// Next-cycle implication, disabled during reset.
`define UVS_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("uvs assertion failed");

`endif

@@ design/uvs_pkg.sv @@
// Package of the UV sphere vertex generator: register codes, CORDIC table,
// pipeline structs and small arithmetic helpers. No dependencies.
package uvs_pkg;

   localparam int unsigned MAX_COUNT    = 1024;
   localparam int          CORDIC_STEPS = 30;
   localparam int          CORDIC_LAT   = CORDIC_STEPS + 2;
   localparam int          DIV_STEPS    = 32;

   localparam logic [1:0] CSR_RADIUS       = 2'd0;
   localparam logic [1:0] CSR_SECTOR_COUNT = 2'd1;
   localparam logic [1:0] CSR_SLICE_COUNT  = 2'd2;

   localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;
   localparam logic signed [31:0] ONE30     = 32'sh4000_0000;

   // Rotation angles in units of 2^-32 turn.
   localparam logic [29:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335086,
      30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41721,
      30'd20860, 30'd10430, 30'd5215, 30'd2607, 30'd1303,
      30'd651, 30'd325, 30'd162, 30'd81, 30'd40,
      30'd20, 30'd10, 30'd5, 30'd2, 30'd1
   };

   typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quadrant_type;

   typedef struct packed {
      logic        oor;
      logic        quad;
      logic [20:0] vnum;
      logic [20:0] bnum;
   } side_type;

   typedef struct packed {
      side_type    side;
      logic [10:0] rs;
      logic [31:0] qs;
      logic [10:0] rl;
      logic [31:0] ql;
      logic [10:0] ru;
      logic [16:0] qu;
      logic [10:0] rv;
      logic [16:0] qv;
   } div_type;

   typedef struct packed {
      side_type    side;
      logic [16:0] tex_u;
      logic [16:0] tex_v;
   } tail_type;

   // One restoring division step: returns {quotient bit, new remainder}.
   function automatic logic [11:0] div_step(input logic [10:0] rem,
                                            input logic bit_in,
                                            input logic [10:0] den);
      logic [11:0] t;
      t = {rem, bit_in};
      if (t >= {1'b0, den})
         return {1'b1, 11'(t - {1'b0, den})};
      else
         return {1'b0, t[10:0]};
   endfunction

   function automatic logic signed [31:0] clamp_unit(input logic signed [32:0] v);
      if (v < 33'sd0)
         return 32'sd0;
      else if (v > 33'(ONE30))
         return ONE30;
      else
         return v[31:0];
   endfunction

   function automatic logic signed [16:0] clamp_pos(input logic signed [63:0] v);
      if (v < -64'sd65535)
         return -17'sd65535;
      else if (v > 64'sd65535)
         return 17'sd65535;
      else
         return v[16:0];
   endfunction

   function automatic logic signed [15:0] clamp_nrm(input logic signed [63:0] v);
      if (v < -64'sd16384)
         return -16'sd16384;
      else if (v > 64'sd16384)
         return 16'sd16384;
      else
         return v[15:0];
   endfunction

endpackage

@@ design/uv_sphere_vertex_generator_top.sv @@
// Top level of the UV sphere vertex generator: config registers, division
// pipeline, two CORDIC instances and the multiply/round stages.
// Depends on uvs_pkg, uvs_cordic and uv_sphere_vertex_generator_top_macros.svh.
//
//   Channel | Direction | Payload
//   req_*   | in        | tdata: slice_index [10:0], sector_index [21:11]
//   rsp_*   | out       | tdata: positions, normals, tex, vertex numbers, quad
//           |           | tuser: out_of_range
//   csr_*   | in        | write enable, register index, 16-bit write data
//
// One beat is accepted per cycle unless the output is held, and each beat yields
// exactly one result beat. The pipeline has one entry stage, 32 long-division
// stages (one quotient bit each; the slice phase and texture divisions stop
// after 31 and 16), 32 CORDIC stages (30 rotations plus entry and quadrant
// mapping), three multiply/round stages and the output register. Reset is
// synchronous and clears the valid bits and loads the default radius and counts.
// When the output beat is held by rsp_tready low the whole pipeline freezes in
// place (nothing is dropped or repeated) and req_tready drops in the same cycle.
`include "uv_sphere_vertex_generator_top_macros.svh"

module uv_sphere_vertex_generator_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // slice_index, sector_index, 2 pad bits
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, tex_u, tex_v,
   // vertex_number, below_number, quad_starts
   output logic [175:0] rsp_tdata,
   output logic [0:0]   rsp_tuser,   // out_of_range
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wr_data
);
   import uvs_pkg::*;

   logic [15:0] radius_ff;
   logic [10:0] sector_count_ff, slice_count_ff;

   // The pipeline moves as one whenever the output register can take a beat.
   logic adv;
   logic rsp_tvalid_ff;
   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   // Configuration registers. Writes must arrive only while the pipeline is empty;
   // the block does not enforce this. Every stage reads the live values.
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff       <= 16'd256;
         sector_count_ff <= 11'd36;
         slice_count_ff  <= 11'd18;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RADIUS:       radius_ff       <= csr_wr_data;
            CSR_SECTOR_COUNT: sector_count_ff <= csr_wr_data[10:0];
            CSR_SLICE_COUNT:  slice_count_ff  <= csr_wr_data[10:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Entry stage: range checks, vertex numbers and the first (integer)
   // quotient bit of each division.
   // ---------------------------------------------------------------------
   logic [10:0] slice_i, sector_j;
   assign slice_i  = req_tdata[10:0];
   assign sector_j = req_tdata[21:11];

   div_type div_ff   [0:DIV_STEPS];
   logic    div_v_ff [0:DIV_STEPS];
   div_type div_in;

   always_comb begin
      logic        count_bad, hs, hl;
      logic [22:0] vnum_full, bnum_full;
      count_bad = (sector_count_ff == 11'd0) || (slice_count_ff == 11'd0) ||
                  ({2'b00, sector_count_ff} > 13'(MAX_COUNT)) ||
                  ({2'b00, slice_count_ff} > 13'(MAX_COUNT));
      hs = (sector_j >= sector_count_ff);
      hl = (slice_i >= slice_count_ff);
      vnum_full = 23'(slice_i) * 23'({1'b0, sector_count_ff} + 12'd1) + 23'(sector_j);
      bnum_full = vnum_full + 23'(sector_count_ff) + 23'd1;
      div_in.side.oor  = count_bad || (slice_i > slice_count_ff) ||
                         (sector_j > sector_count_ff);
      div_in.side.quad = (slice_i < slice_count_ff) && (sector_j < sector_count_ff);
      div_in.side.vnum = vnum_full[20:0];
      div_in.side.bnum = bnum_full[20:0];
      div_in.rs = hs ? 11'(sector_j - sector_count_ff) : sector_j;
      div_in.qs = '0;
      div_in.ru = div_in.rs;
      div_in.qu = {16'b0, hs};
      div_in.rl = hl ? 11'(slice_i - slice_count_ff) : slice_i;
      div_in.ql = {31'b0, hl};
      div_in.rv = div_in.rl;
      div_in.qv = {16'b0, hl};
   end

   always_ff @(posedge clock) begin
      if (reset)
         div_v_ff[0] <= 1'b0;
      else if (adv)
         div_v_ff[0] <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (adv)
         div_ff[0] <= div_in;
   end

   // ---------------------------------------------------------------------
   // Long division, one quotient bit per stage. The dividends are
   // index * 2^n plus half the count, so the low bits shifted in are the
   // bits of half the count.
   // ---------------------------------------------------------------------
   logic [31:0] sec_half;
   logic [30:0] lat_half;
   logic [15:0] sec_half16, lat_half16;
   assign sec_half   = {22'b0, sector_count_ff[10:1]};
   assign lat_half   = {21'b0, slice_count_ff[10:1]};
   assign sec_half16 = {6'b0, sector_count_ff[10:1]};
   assign lat_half16 = {6'b0, slice_count_ff[10:1]};

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      localparam bit LAT_ON = (k < 31);
      localparam bit TEX_ON = (k < 16);
      localparam int LB     = LAT_ON ? 30 - k : 0;
      localparam int TB     = TEX_ON ? 15 - k : 0;
      logic [11:0] sec_st, lat_st, tu_st, tv_st;
      div_type     stage_in;
      assign sec_st = div_step(div_ff[k].rs, sec_half[31-k], sector_count_ff);
      assign lat_st = div_step(div_ff[k].rl, lat_half[LB], slice_count_ff);
      assign tu_st  = div_step(div_ff[k].ru, sec_half16[TB], sector_count_ff);
      assign tv_st  = div_step(div_ff[k].rv, lat_half16[TB], slice_count_ff);
      always_comb begin
         stage_in    = div_ff[k];
         stage_in.rs = sec_st[10:0];
         stage_in.qs = {div_ff[k].qs[30:0], sec_st[11]};
         if (LAT_ON) begin
            stage_in.rl = lat_st[10:0];
            stage_in.ql = {div_ff[k].ql[30:0], lat_st[11]};
         end
         if (TEX_ON) begin
            stage_in.ru = tu_st[10:0];
            stage_in.qu = {div_ff[k].qu[15:0], tu_st[11]};
            stage_in.rv = tv_st[10:0];
            stage_in.qv = {div_ff[k].qv[15:0], tv_st[11]};
         end
      end
      always_ff @(posedge clock) begin
         if (reset)
            div_v_ff[k+1] <= 1'b0;
         else if (adv)
            div_v_ff[k+1] <= div_v_ff[k];
      end
      always_ff @(posedge clock) begin
         if (adv)
            div_ff[k+1] <= stage_in;
      end
   end

   // ---------------------------------------------------------------------
   // Sine and cosine of both angles. The slice phase is a quarter turn
   // minus the quotient; side data rides a delay line of equal length.
   // ---------------------------------------------------------------------
   logic [31:0]        sec_phase, lat_phase;
   logic signed [31:0] cs, ss, cl, sl;
   assign sec_phase = div_ff[DIV_STEPS].qs;
   assign lat_phase = 32'h4000_0000 - div_ff[DIV_STEPS].ql;

   uvs_cordic u_cordic_sector (
      .clock   (clock),
      .adv     (adv),
      .phase   (sec_phase),
      .cos_out (cs),
      .sin_out (ss)
   );

   uvs_cordic u_cordic_slice (
      .clock   (clock),
      .adv     (adv),
      .phase   (lat_phase),
      .cos_out (cl),
      .sin_out (sl)
   );

   tail_type tl_ff   [0:CORDIC_LAT-1];
   logic     tl_v_ff [0:CORDIC_LAT-1];

   always_ff @(posedge clock) begin
      if (reset)
         tl_v_ff[0] <= 1'b0;
      else if (adv)
         tl_v_ff[0] <= div_v_ff[DIV_STEPS];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tl_ff[0].side  <= div_ff[DIV_STEPS].side;
         tl_ff[0].tex_u <= div_ff[DIV_STEPS].qu;
         tl_ff[0].tex_v <= div_ff[DIV_STEPS].qv;
      end
   end

   for (genvar k = 1; k < CORDIC_LAT; k++) begin : g_tail
      always_ff @(posedge clock) begin
         if (reset)
            tl_v_ff[k] <= 1'b0;
         else if (adv)
            tl_v_ff[k] <= tl_v_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (adv)
            tl_ff[k] <= tl_ff[k-1];
      end
   end

   // ---------------------------------------------------------------------
   // M1: first products (radius by slice terms, normal x and y products).
   // ---------------------------------------------------------------------
   logic signed [16:0] rad_s;
   assign rad_s = signed'({1'b0, radius_ff});

   logic               m1_v_ff;
   tail_type           m1_tl_ff;
   logic signed [48:0] m1_xy_ff, m1_z_ff, m1_xy_in, m1_z_in;
   logic signed [63:0] m1_nx_ff, m1_ny_ff, m1_nx_in, m1_ny_in;
   logic signed [31:0] m1_sl_ff, m1_cs_ff, m1_ss_ff;

   assign m1_xy_in = rad_s * cl;
   assign m1_z_in  = rad_s * sl;
   assign m1_nx_in = cl * cs;
   assign m1_ny_in = cl * ss;

   always_ff @(posedge clock) begin
      if (reset)
         m1_v_ff <= 1'b0;
      else if (adv)
         m1_v_ff <= tl_v_ff[CORDIC_LAT-1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_tl_ff <= tl_ff[CORDIC_LAT-1];
         m1_xy_ff <= m1_xy_in;
         m1_z_ff  <= m1_z_in;
         m1_nx_ff <= m1_nx_in;
         m1_ny_ff <= m1_ny_in;
         m1_sl_ff <= sl;
         m1_cs_ff <= cs;
         m1_ss_ff <= ss;
      end
   end

   // ---------------------------------------------------------------------
   // M2: round the ring radius, pos_z and the normals.
   // ---------------------------------------------------------------------
   logic               m2_v_ff;
   tail_type           m2_tl_ff;
   logic signed [26:0] m2_xy_ff, m2_xy_in;
   logic signed [16:0] m2_pz_ff, m2_pz_in;
   logic signed [15:0] m2_nx_ff, m2_ny_ff, m2_nz_ff, m2_nx_in, m2_ny_in, m2_nz_in;
   logic signed [31:0] m2_cs_ff, m2_ss_ff;

   always_comb begin
      logic signed [48:0] xy_sum, z_sum;
      logic signed [63:0] nx_sum, ny_sum, nz_sum;
      xy_sum   = m1_xy_ff + 49'sd2097152;
      z_sum    = m1_z_ff + 49'sd536870912;
      nx_sum   = m1_nx_ff + 64'sh0000_2000_0000_0000;
      ny_sum   = m1_ny_ff + 64'sh0000_2000_0000_0000;
      nz_sum   = 64'(m1_sl_ff) + 64'sd32768;
      m2_xy_in = 27'(xy_sum >>> 22);
      m2_pz_in = clamp_pos(64'(z_sum >>> 30));
      m2_nx_in = clamp_nrm(nx_sum >>> 46);
      m2_ny_in = clamp_nrm(ny_sum >>> 46);
      m2_nz_in = clamp_nrm(nz_sum >>> 16);
   end

   always_ff @(posedge clock) begin
      if (reset)
         m2_v_ff <= 1'b0;
      else if (adv)
         m2_v_ff <= m1_v_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m2_tl_ff <= m1_tl_ff;
         m2_xy_ff <= m2_xy_in;
         m2_pz_ff <= m2_pz_in;
         m2_nx_ff <= m2_nx_in;
         m2_ny_ff <= m2_ny_in;
         m2_nz_ff <= m2_nz_in;
         m2_cs_ff <= m1_cs_ff;
         m2_ss_ff <= m1_ss_ff;
      end
   end

   // ---------------------------------------------------------------------
   // M3: ring radius times the sector cosine and sine.
   // ---------------------------------------------------------------------
   logic               m3_v_ff;
   tail_type           m3_tl_ff;
   logic signed [63:0] m3_px_ff, m3_py_ff, m3_px_in, m3_py_in;
   logic signed [16:0] m3_pz_ff;
   logic signed [15:0] m3_nx_ff, m3_ny_ff, m3_nz_ff;

   assign m3_px_in = m2_xy_ff * m2_cs_ff;
   assign m3_py_in = m2_xy_ff * m2_ss_ff;

   always_ff @(posedge clock) begin
      if (reset)
         m3_v_ff <= 1'b0;
      else if (adv)
         m3_v_ff <= m2_v_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m3_tl_ff <= m2_tl_ff;
         m3_px_ff <= m3_px_in;
         m3_py_ff <= m3_py_in;
         m3_pz_ff <= m2_pz_ff;
         m3_nx_ff <= m2_nx_ff;
         m3_ny_ff <= m2_ny_ff;
         m3_nz_ff <= m2_nz_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Output register: final rounding, and a flagged beat carries zeros.
   // ---------------------------------------------------------------------
   logic [175:0] rsp_tdata_ff, rsp_tdata_in;
   logic         rsp_oor_ff;

   always_comb begin
      logic signed [16:0] px, py;
      px = clamp_pos((m3_px_ff + 64'sh0000_0020_0000_0000) >>> 38);
      py = clamp_pos((m3_py_ff + 64'sh0000_0020_0000_0000) >>> 38);
      rsp_tdata_in = {m3_tl_ff.side.quad, m3_tl_ff.side.bnum, m3_tl_ff.side.vnum,
                      m3_tl_ff.tex_v, m3_tl_ff.tex_u,
                      m3_nz_ff, m3_ny_ff, m3_nx_ff, m3_pz_ff, py, px};
      if (m3_tl_ff.side.oor)
         rsp_tdata_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_tvalid_ff <= 1'b0;
      else if (adv)
         rsp_tvalid_ff <= m3_v_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_oor_ff   <= m3_tl_ff.side.oor;
      end
   end

   assign rsp_tvalid   = rsp_tvalid_ff;
   assign rsp_tdata    = rsp_tdata_ff;
   assign rsp_tuser[0] = rsp_oor_ff;

   // Field views of the output register for the checks below.
   logic [20:0]        rsp_vnum, rsp_bnum, row_step;
   logic signed [15:0] rsp_nz;
   assign rsp_vnum = rsp_tdata_ff[153:133];
   assign rsp_bnum = rsp_tdata_ff[174:154];
   assign rsp_nz   = rsp_tdata_ff[98:83];
   assign row_step = 21'(sector_count_ff) + 21'd1;

   // A flagged result carries nothing but the flag.
   `UVS_ASSERT_IMP(a_flag_zeroes_data, rsp_tvalid_ff && rsp_oor_ff, rsp_tdata_ff == '0)
   // The vertex below sits one row of sector_count + 1 further on.
   `UVS_ASSERT_IMP(a_below_number, rsp_tvalid_ff && !rsp_oor_ff, rsp_bnum == rsp_vnum + row_step)
   // A quad never starts at a flagged point.
   `UVS_ASSERT_IMP(a_quad_not_flagged, rsp_tvalid_ff && rsp_tdata_ff[175], !rsp_oor_ff)
   // A held output beat freezes the valid bits inside the pipeline.
   `UVS_ASSERT_NXT(a_stall_freezes, !adv, $stable(m3_v_ff) && $stable(tl_v_ff[0]) && $stable(div_v_ff[0]))
   // The z normal never leaves the unit range.
   `UVS_ASSERT_IMP(a_normal_z_range, rsp_tvalid_ff, (rsp_nz <= 16'sd16384) && (rsp_nz >= -16'sd16384))

endmodule

@@ design/uvs_cordic.sv @@
// Pipelined rotation CORDIC: 32-bit phase (one turn = 2^32) to cosine and sine
// in Q2.30. Depends on uvs_pkg. All stages advance only on adv.
module uvs_cordic (
   input  logic               clock,
   input  logic               adv,
   input  logic [31:0]        phase,
   output logic signed [31:0] cos_out,
   output logic signed [31:0] sin_out
);
   import uvs_pkg::*;

   logic signed [32:0] x_ff    [0:CORDIC_STEPS];
   logic signed [32:0] y_ff    [0:CORDIC_STEPS];
   logic signed [31:0] z_ff    [0:CORDIC_STEPS];
   quadrant_type       q_ff    [0:CORDIC_STEPS];
   logic               zero_ff [0:CORDIC_STEPS];
   logic signed [31:0] cos_ff, sin_ff, cos_in, sin_in;

   // Entry: split the phase into quadrant and residual angle.
   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0]    <= CORDIC_X0;
         y_ff[0]    <= '0;
         z_ff[0]    <= signed'({2'b00, phase[29:0]});
         q_ff[0]    <= quadrant_type'(phase[31:30]);
         zero_ff[0] <= (phase[29:0] == 30'd0);
      end
   end

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
      logic signed [32:0] x_in, y_in;
      logic signed [31:0] z_in;
      always_comb begin
         if (!z_ff[k][31]) begin
            x_in = x_ff[k] - (y_ff[k] >>> k);
            y_in = y_ff[k] + (x_ff[k] >>> k);
            z_in = z_ff[k] - signed'({2'b00, ATAN_TURNS[k]});
         end else begin
            x_in = x_ff[k] + (y_ff[k] >>> k);
            y_in = y_ff[k] - (x_ff[k] >>> k);
            z_in = z_ff[k] + signed'({2'b00, ATAN_TURNS[k]});
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[k+1]    <= x_in;
            y_ff[k+1]    <= y_in;
            z_ff[k+1]    <= z_in;
            q_ff[k+1]    <= q_ff[k];
            zero_ff[k+1] <= zero_ff[k];
         end
      end
   end

   // Clamp to the first quadrant, then rotate by the quadrant.
   always_comb begin
      logic signed [31:0] c, s;
      if (zero_ff[CORDIC_STEPS]) begin
         c = ONE30;
         s = '0;
      end else begin
         c = clamp_unit(x_ff[CORDIC_STEPS]);
         s = clamp_unit(y_ff[CORDIC_STEPS]);
      end
      unique case (q_ff[CORDIC_STEPS])
         QUAD_I:   begin cos_in = c;  sin_in = s;  end
         QUAD_II:  begin cos_in = -s; sin_in = c;  end
         QUAD_III: begin cos_in = -c; sin_in = -s; end
         QUAD_IV:  begin cos_in = s;  sin_in = -c; end
         default:  begin cos_in = c;  sin_in = s;  end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the UV sphere vertex generator top level.
// Depends on uvs_pkg and the design; it predicts every result beat and compares.
`timescale 1ns / 1ps

module tb;
   import uvs_pkg::*;

   // Result beat as it lies on rsp_tdata, highest field first.
   typedef struct packed {
      logic              quad;
      logic [20:0]       bnum;
      logic [20:0]       vnum;
      logic [16:0]       tex_v;
      logic [16:0]       tex_u;
      logic signed [15:0] nz;
      logic signed [15:0] ny;
      logic signed [15:0] nx;
      logic signed [16:0] pz;
      logic signed [16:0] py;
      logic signed [16:0] px;
   } vertex_beat_type;

   typedef struct {
      vertex_beat_type beat;
      logic            oor;
   } vertex_type;

   // Register index that maps to no register; writes to it are ignored.
   localparam logic [1:0] CSR_SPARE = 2'd3;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [23:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [175:0] rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_wr_en = 1'b0;
   logic [1:0]   csr_index = CSR_RADIUS;
   logic [15:0]  csr_wr_data = '0;

   // Our own copy of the configuration, following every write we make.
   logic [15:0] sphere_radius;
   logic [10:0] sector_cnt;
   logic [10:0] slice_cnt;

   vertex_type  vertex_q[$];
   int          mismatches = 0;
   int          beats_checked = 0;
   int          flagged_checked = 0;
   int          config_writes = 0;
   bit          no_idle = 1'b0;     // phase with both sides running flat out
   bit          hold_request = 1'b0; // asks the receiver for one long hold-off

   localparam int DRAIN_CYCLES = 80; // more than the pipeline latency

   localparam longint ATAN_TAB [0:29] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335086, 667544, 333772, 166886, 83443,
      41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81, 40, 20,
      10, 5, 2, 1
   };

   uv_sphere_vertex_generator_top u_top (.*);

   always #5 clock = ~clock;

   initial begin
      #10ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Predictor. Positions, normals and texture coordinates are worked out
   // from the grid point with the same fixed-point rounding the block uses.
   // ---------------------------------------------------------------------

   // Round to nearest with ties up, then drop k fraction bits.
   function automatic longint round_shift(longint v, int k);
      return (v + (64'sd1 <<< (k - 1))) >>> k;
   endfunction

   function automatic longint saturate(longint v, longint lim);
      return v < -lim ? -lim : (v > lim ? lim : v);
   endfunction

   // Cosine and sine of a phase given in 2^-32 turns, both in Q2.30.
   function automatic void turn_sincos(input logic [31:0] phase,
                                       output longint co, output longint si);
      longint x, y, z, dx, dy, c, s;
      x = 652032874;
      y = 0;
      z = phase[29:0];
      if (z == 0) begin
         c = 64'sd1 <<< 30;
         s = 0;
      end else begin
         for (int k = 0; k < 30; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
               x = x - dx; y = y + dy; z = z - ATAN_TAB[k];
            end else begin
               x = x + dx; y = y - dy; z = z + ATAN_TAB[k];
            end
         end
         c = x < 0 ? 0 : (x > (64'sd1 <<< 30) ? (64'sd1 <<< 30) : x);
         s = y < 0 ? 0 : (y > (64'sd1 <<< 30) ? (64'sd1 <<< 30) : y);
      end
      case (quadrant_type'(phase[31:30]))
         QUAD_I: begin
            co = c; si = s;
         end
         QUAD_II: begin
            co = -s; si = c;
         end
         QUAD_III: begin
            co = -c; si = -s;
         end
         default: begin
            co = s; si = -c;
         end
      endcase
   endfunction

   function automatic vertex_type predict_vertex(logic [10:0] slice, logic [10:0] sector);
      vertex_type v;
      longint  ns, nl, li, lj, r, cs, ss, cl, sl, xy, vnum;
      logic [31:0] ph_sector, ph_slice;
      v.beat = '0;
      v.oor = 1'b0;
      ns = sector_cnt;
      nl = slice_cnt;
      li = slice;
      lj = sector;
      if (ns == 0 || nl == 0 || ns > MAX_COUNT || nl > MAX_COUNT || li > nl || lj > ns) begin
         v.oor = 1'b1;
         return v;
      end
      ph_sector = 32'(((lj <<< 32) + ns / 2) / ns);
      ph_slice = 32'h4000_0000 - 32'(((li <<< 31) + nl / 2) / nl);
      turn_sincos(ph_sector, cs, ss);
      turn_sincos(ph_slice, cl, sl);
      r = sphere_radius;
      xy = round_shift(r * cl, 22);
      v.beat.px = 17'(saturate(round_shift(xy * cs, 38), 65535));
      v.beat.py = 17'(saturate(round_shift(xy * ss, 38), 65535));
      v.beat.pz = 17'(saturate(round_shift(r * sl, 30), 65535));
      v.beat.nx = 16'(saturate(round_shift(cl * cs, 46), 16384));
      v.beat.ny = 16'(saturate(round_shift(cl * ss, 46), 16384));
      v.beat.nz = 16'(saturate(round_shift(sl, 16), 16384));
      v.beat.tex_u = 17'((lj * 65536 + ns / 2) / ns);
      v.beat.tex_v = 17'((li * 65536 + nl / 2) / nl);
      vnum = li * (ns + 1) + lj;
      v.beat.vnum = 21'(vnum);
      v.beat.bnum = 21'(vnum + ns + 1);
      v.beat.quad = (li < nl) && (lj < ns);
      return v;
   endfunction

   // ---------------------------------------------------------------------
   // Checker. Each accepted result beat is matched against the oldest
   // predicted vertex, field by field.
   // ---------------------------------------------------------------------

   task automatic compare_field(string name, longint expected, longint actual);
      if (expected != actual) begin
         $display("%0t ERROR %s expected %0d actual %0d", $time, name, expected, actual);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      vertex_type      exp_v;
      vertex_beat_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (vertex_q.size() == 0) begin
            $display("%0t ERROR unexpected result beat, expected none actual %h",
                     $time, rsp_tdata);
            mismatches++;
         end else begin
            exp_v = vertex_q.pop_front();
            compare_field("out_of_range", exp_v.oor, rsp_tuser[0]);
            compare_field("pos_x", exp_v.beat.px, got.px);
            compare_field("pos_y", exp_v.beat.py, got.py);
            compare_field("pos_z", exp_v.beat.pz, got.pz);
            compare_field("normal_x", exp_v.beat.nx, got.nx);
            compare_field("normal_y", exp_v.beat.ny, got.ny);
            compare_field("normal_z", exp_v.beat.nz, got.nz);
            compare_field("tex_u", exp_v.beat.tex_u, got.tex_u);
            compare_field("tex_v", exp_v.beat.tex_v, got.tex_v);
            compare_field("vertex_number", exp_v.beat.vnum, got.vnum);
            compare_field("below_number", exp_v.beat.bnum, got.bnum);
            compare_field("quad_starts", exp_v.beat.quad, got.quad);
            beats_checked++;
            if (exp_v.oor)
               flagged_checked++;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver. Mostly ready, with short and occasional long stalls. A hold
   // request makes it refuse beats for a long hold-off so the pipeline backs up.
   // ---------------------------------------------------------------------

   always @(negedge clock) begin
      int unsigned stall_left;
      int unsigned hold_left;
      if (hold_request) begin
         hold_left = 300;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if (!no_idle && $urandom_range(0, 3) == 0)
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 3);
      end
   end

   // ---------------------------------------------------------------------
   // Sender side. One beat per call; the prediction is queued at the edge
   // that accepts the beat. Valid is only dropped when a gap follows.
   // ---------------------------------------------------------------------

   task automatic send_point(logic [10:0] slice, logic [10:0] sector);
      int unsigned gap;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = {2'b00, sector, slice};
      do
         @(posedge clock);
      while (!req_tready);
      vertex_q.push_back(predict_vertex(slice, sector));
      gap = 0;
      if (!no_idle && $urandom_range(0, 2) == 0)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Lets every expected beat come out, then lets the pipeline run dry.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (vertex_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] index, logic [15:0] value);
      wait_idle();
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = index;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      config_writes++;
      case (index)
         CSR_RADIUS:       sphere_radius = value;
         CSR_SECTOR_COUNT: sector_cnt = value[10:0];
         CSR_SLICE_COUNT:  slice_cnt = value[10:0];
         default: ; // unused index, the block ignores it
      endcase
   endtask

   // Mostly grid points inside the sphere, some on or just past the last row,
   // and some noise over the full 11-bit range.
   task automatic send_random_point();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         send_point(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)));
      else if (pick == 1)
         send_point(11'(slice_cnt + $urandom_range(0, 2)),
                    11'($urandom_range(0, sector_cnt)));
      else
         send_point(11'($urandom_range(0, slice_cnt)), 11'($urandom_range(0, sector_cnt)));
   endtask

   // ---------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------

   // Default configuration after reset: poles, equator, each quadrant of
   // the sector angle, the last row and column, and indices past the counts.
   task automatic test_reset_defaults();
      send_point(0, 0);
      send_point(18, 36);
      send_point(9, 0);
      send_point(9, 9);
      send_point(9, 18);
      send_point(9, 27);
      send_point(1, 35);
      send_point(19, 0);
      send_point(0, 37);
      send_point(11'h7FF, 11'h7FF);
   endtask

   // Register extremes: zero and full radius, counts of one and the maximum,
   // bad counts, and a write to an unused index that must change nothing.
   task automatic test_config_extremes();
      write_reg(CSR_RADIUS, 16'd0);
      send_point(4, 5);
      send_point(9, 0);
      write_reg(CSR_RADIUS, 16'hFFFF);
      write_reg(CSR_SECTOR_COUNT, 16'd1);
      write_reg(CSR_SLICE_COUNT, 16'd1);
      send_point(0, 0);
      send_point(1, 1);
      send_point(0, 1);
      send_point(1, 0);
      write_reg(CSR_SECTOR_COUNT, 16'd1024);
      write_reg(CSR_SLICE_COUNT, 16'd1024);
      send_point(1024, 1024);
      send_point(512, 256);
      send_point(1023, 1023);
      send_point(11'h555, 11'h2AA);
      write_reg(CSR_SPARE, 16'd7);
      send_point(3, 3);
      write_reg(CSR_SECTOR_COUNT, 16'd0);
      send_point(0, 0);
      write_reg(CSR_SECTOR_COUNT, 16'd1025);
      send_point(1, 1);
      write_reg(CSR_SECTOR_COUNT, 16'h0805);
      send_point(2, 5);
      write_reg(CSR_SLICE_COUNT, 16'd2047);
      send_point(2, 2);
   endtask

   // Random grid points over a series of settings, the last one run with no
   // idling on either side.
   task automatic test_random_settings();
      for (int round = 0; round < 6; round++) begin
         write_reg(CSR_RADIUS, round == 0 ? 16'd1 : 16'($urandom_range(1, 65535)));
         write_reg(CSR_SECTOR_COUNT, 16'($urandom_range(1, round < 3 ? 64 : 1024)));
         write_reg(CSR_SLICE_COUNT, 16'($urandom_range(1, round < 3 ? 64 : 1024)));
         no_idle = (round == 5);
         repeat (90) send_random_point();
      end
      no_idle = 1'b0;
   endtask

   // The receiver holds off for a long stretch while beats keep coming, so
   // the pipeline fills and the input stalls.
   task automatic test_output_hold();
      wait_idle();
      hold_request = 1'b1;
      repeat (100) send_random_point();
   endtask

   // The sender pauses until every result is out, then goes on.
   task automatic test_drain_pause();
      repeat (20) send_random_point();
      wait_idle();
      repeat (20) send_random_point();
   endtask

   initial begin
      sphere_radius = 16'd256;
      sector_cnt = 11'd36;
      slice_cnt = 11'd18;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_config_extremes();
      test_random_settings();
      test_output_hold();
      test_drain_pause();

      wait_idle();
      $display("Checked %0d result beats (%0d flagged out of range) over %0d register writes.",
               beats_checked, flagged_checked, config_writes);
      $display("Covered poles, equator, count extremes, bad counts, back-pressure and drains.");
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
